/* hw/rtl/image_border_padding_macros.svh */
// Assertion macros for the RTL
`ifndef IMAGE_BORDER_PADDING_MACROS_SVH
`define IMAGE_BORDER_PADDING_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define IBP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ibp assertion failed");
// checked also during reset
`define IBP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ibp assertion failed");
`else
`define IBP_ASSERT(lbl, clk, rst_n, prop)
`define IBP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* hw/rtl/ibp_pkg.sv */
package ibp_pkg;

  localparam int unsigned CFG_W     = 7;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned FILL_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH      = 3'd0,
    CFG_HEIGHT     = 3'd1,
    CFG_PAD_TOP    = 3'd2,
    CFG_PAD_BOTTOM = 3'd3,
    CFG_PAD_LEFT   = 3'd4,
    CFG_PAD_RIGHT  = 3'd5,
    CFG_MODE       = 3'd6,
    CFG_FILL       = 3'd7
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_CONSTANT    = 3'd0,
    MODE_REPLICATE   = 3'd1,
    MODE_REFLECT     = 3'd2,
    MODE_WRAP        = 3'd3,
    MODE_REFLECT_101 = 3'd4
  } border_mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_WR,
    S_EM_RED,
    S_EM_ADR,
    S_EM_RD,
    S_EM_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic accept;     // capture item, start load or emit
    logic ld_write;   // write load byte into the frame store
    logic reduce;     // one modulo step on both coordinates
    logic addr_calc;  // fold coordinates, pixel base address
    logic rd_issue;   // frame store read
    logic out_load;   // result into output register
  } ibp_cmd_t;

  typedef struct packed {
    logic reduce_done;
    logic out_free;
  } ibp_sts_t;

endpackage

/* hw/rtl/ibp_if.sv */
interface ibp_in_if import ibp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] src_byte;

  modport source (output valid, output req_type, output src_byte, input ready);
  modport sink (input valid, input req_type, input src_byte, output ready);
endinterface

interface ibp_out_if import ibp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pad_byte;
  logic              frame_last;

  modport source (output valid, output pad_byte, output frame_last, input ready);
  modport sink (input valid, input pad_byte, input frame_last, output ready);
endinterface

interface ibp_cfg_if import ibp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FILL_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/ibp_ram.sv */
module ibp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 12288
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ibp_ctrl.sv */
module ibp_ctrl import ibp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     req_type_i,
  input  ibp_sts_t sts_i,
  output logic     in_ready_o,
  output ibp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = req_type_i ? S_EM_RED : S_LD_WR;
        end
      end
      S_LD_WR: begin
        cmd_o.ld_write = 1'b1;
        state_d        = S_IDLE;
      end
      S_EM_RED: begin
        if (sts_i.reduce_done) begin
          state_d = S_EM_ADR;
        end else begin
          cmd_o.reduce = 1'b1;
        end
      end
      S_EM_ADR: begin
        cmd_o.addr_calc = 1'b1;
        state_d         = S_EM_RD;
      end
      S_EM_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/ibp_datapath.sv */
module ibp_datapath import ibp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned CHANNELS   = 3,
  parameter int unsigned MAX_PAD    = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ibp_cmd_t             cmd_i,
  output ibp_sts_t             sts_o,
  input  logic                 req_type_i,
  input  logic [BYTE_W-1:0]    src_byte_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FILL_W-1:0]    cfg_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [BYTE_W-1:0]    pad_byte_o,
  output logic                 frame_last_o
);

  localparam int unsigned DEPTH   = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned FBW     = $clog2(DEPTH + 1);
  localparam int unsigned WHW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned BW      = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned LEN_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned LW      = $clog2(LEN_MAX + 1);
  localparam int unsigned PW      = $clog2(MAX_PAD + 2);
  localparam int unsigned CW      = $clog2(LEN_MAX + 2 * MAX_PAD + 1);
  localparam int unsigned QW      = CW + 2;
  localparam int unsigned CHW     = $clog2(CHANNELS + 1);

  // configuration registers
  logic [CFG_W-1:0]  width_q, height_q, pt_q, pb_q, pl_q, pr_q;
  logic [MODE_W-1:0] mode_q;
  logic [FILL_W-1:0] fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(64);
      height_q <= CFG_W'(64);
      pt_q     <= '0;
      pb_q     <= '0;
      pl_q     <= '0;
      pr_q     <= '0;
      mode_q   <= MODE_CONSTANT;
      fill_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:      width_q  <= cfg_data_i[CFG_W-1:0];
        CFG_HEIGHT:     height_q <= cfg_data_i[CFG_W-1:0];
        CFG_PAD_TOP:    pt_q     <= cfg_data_i[CFG_W-1:0];
        CFG_PAD_BOTTOM: pb_q     <= cfg_data_i[CFG_W-1:0];
        CFG_PAD_LEFT:   pl_q     <= cfg_data_i[CFG_W-1:0];
        CFG_PAD_RIGHT:  pr_q     <= cfg_data_i[CFG_W-1:0];
        CFG_MODE:       mode_q   <= cfg_data_i[MODE_W-1:0];
        CFG_FILL:       fill_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [LW-1:0] w_eff, h_eff;
  logic [PW-1:0] pt_eff, pb_eff, pl_eff, pr_eff;

  function automatic logic [LW-1:0] clamp_len(logic [CFG_W-1:0] v, int unsigned mx);
    int unsigned t;
    t = int'(v);
    if (t < 1) t = 1;
    if (t > mx) t = mx;
    return LW'(t);
  endfunction

  function automatic logic [PW-1:0] clamp_pad(logic [CFG_W-1:0] v);
    int unsigned t;
    t = int'(v);
    if (t > MAX_PAD) t = MAX_PAD;
    return PW'(t);
  endfunction

  assign w_eff  = clamp_len(width_q, MAX_WIDTH);
  assign h_eff  = clamp_len(height_q, MAX_HEIGHT);
  assign pt_eff = clamp_pad(pt_q);
  assign pb_eff = clamp_pad(pb_q);
  assign pl_eff = clamp_pad(pl_q);
  assign pr_eff = clamp_pad(pr_q);

  logic cyclic, replicate;
  assign cyclic    = (mode_q == MODE_REFLECT) || (mode_q == MODE_WRAP) ||
                     (mode_q == MODE_REFLECT_101);
  assign replicate = (mode_q == MODE_REPLICATE);

  // period of the cyclic border rules; zero for reflect-101 on a length of one
  function automatic logic signed [QW-1:0] period(logic [LW-1:0] n, logic [MODE_W-1:0] m);
    logic signed [QW-1:0] ne;
    ne = QW'(n);
    if (m == MODE_REFLECT) return ne <<< 1;
    if (m == MODE_REFLECT_101) return (ne <<< 1) - QW'(2);
    return ne;
  endfunction

  function automatic logic [LW-1:0] fold(logic signed [QW-1:0] q, logic [LW-1:0] n,
                                         logic [MODE_W-1:0] m);
    logic signed [QW-1:0] ne;
    ne = QW'(n);
    if (m == MODE_REPLICATE) begin
      if (q < 0) return '0;
      if (q >= ne) return n - LW'(1);
      return LW'(q);
    end
    if (m == MODE_REFLECT_101 && n == LW'(1)) return '0;
    if (q < ne) return LW'(q);
    if (m == MODE_REFLECT) return LW'((ne <<< 1) - QW'(1) - q);
    if (m == MODE_REFLECT_101) return LW'((ne <<< 1) - QW'(2) - q);
    return LW'(q);
  endfunction

  logic signed [QW-1:0] per_c, per_r;
  assign per_c = period(w_eff, mode_q);
  assign per_r = period(h_eff, mode_q);

  // output position counters
  logic [CW-1:0]  col_q, row_q, nw, nh, cur_col, cur_row;
  logic [CHW-1:0] chpos_q, cur_ch;
  logic           pos_bad, last_d;

  assign nw      = CW'(w_eff) + CW'(pl_eff) + CW'(pr_eff);
  assign nh      = CW'(h_eff) + CW'(pt_eff) + CW'(pb_eff);
  assign pos_bad = (row_q >= nh) || (col_q >= nw) || (chpos_q >= CHW'(CHANNELS));
  assign cur_col = pos_bad ? '0 : col_q;
  assign cur_row = pos_bad ? '0 : row_q;
  assign cur_ch  = pos_bad ? '0 : chpos_q;
  assign last_d  = (cur_row == nh - CW'(1)) && (cur_col == nw - CW'(1)) &&
                   (cur_ch == CHW'(CHANNELS - 1));

  logic signed [QW-1:0] pc, pr;
  assign pc = QW'(cur_col) - QW'(pl_eff);
  assign pr = QW'(cur_row) - QW'(pt_eff);

  logic emit_start, load_start;
  assign emit_start = cmd_i.accept && req_type_i;
  assign load_start = cmd_i.accept && !req_type_i;

  // per-item registers
  logic signed [QW-1:0] qc_q, qr_q;
  logic [CHW-1:0]       ech_q;
  logic                 elast_q, fill_sel_q;
  logic [BYTE_W-1:0]    lbyte_q;
  logic [WHW-1:0]       wh_q;
  logic [BW-1:0]        base_q;

  function automatic logic signed [QW-1:0] red_step(logic signed [QW-1:0] q,
                                                    logic signed [QW-1:0] p);
    if (q < 0) return q + p;
    if (q >= p) return q - p;
    return q;
  endfunction

  function automatic logic in_period(logic signed [QW-1:0] q, logic signed [QW-1:0] p);
    return (p == '0) || (q >= 0 && q < p);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      chpos_q <= '0;
    end else if (emit_start) begin
      if (cur_ch == CHW'(CHANNELS - 1)) begin
        chpos_q <= '0;
        if (cur_col == nw - CW'(1)) begin
          col_q <= '0;
          row_q <= (cur_row == nh - CW'(1)) ? '0 : cur_row + CW'(1);
        end else begin
          col_q <= cur_col + CW'(1);
          row_q <= cur_row;
        end
      end else begin
        chpos_q <= cur_ch + CHW'(1);
        col_q   <= cur_col;
        row_q   <= cur_row;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_start) begin
      qc_q       <= pc;
      qr_q       <= pr;
      ech_q      <= cur_ch;
      elast_q    <= last_d;
      fill_sel_q <= !cyclic && !replicate &&
                    (pc < 0 || pc >= QW'(w_eff) || pr < 0 || pr >= QW'(h_eff));
    end else if (cmd_i.reduce) begin
      qc_q <= red_step(qc_q, per_c);
      qr_q <= red_step(qr_q, per_r);
    end
    if (load_start) begin
      lbyte_q <= src_byte_i;
      wh_q    <= WHW'(w_eff * h_eff);
    end
    if (cmd_i.addr_calc) begin
      base_q <= BW'(fold(qr_q, h_eff, mode_q) * w_eff) + BW'(fold(qc_q, w_eff, mode_q));
    end
  end

  assign sts_o.reduce_done = !cyclic || (in_period(qc_q, per_c) && in_period(qr_q, per_r));

  // load address, wraps at the current image size
  logic [AW-1:0]  lp_q, waddr, lp_next;
  logic [FBW-1:0] fb;
  assign fb      = FBW'(wh_q) * FBW'(CHANNELS);
  assign waddr   = (FBW'(lp_q) >= fb) ? '0 : lp_q;
  assign lp_next = (FBW'(waddr) + FBW'(1) >= fb) ? '0 : waddr + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0;
    end else if (cmd_i.ld_write) begin
      lp_q <= lp_next;
    end
  end

  logic [AW-1:0]     raddr;
  logic [BYTE_W-1:0] rdata;
  assign raddr = AW'(base_q * CHANNELS) + AW'(ech_q);

  ibp_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ld_write),
    .waddr_i(waddr),
    .wdata_i(lbyte_q),
    .re_i   (cmd_i.rd_issue),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // output register
  logic              out_valid_q, out_last_q;
  logic [BYTE_W-1:0] out_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_byte_q <= fill_sel_q ? fill_q[{ech_q, 3'b000} +: BYTE_W] : rdata;
      out_last_q <= elast_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign pad_byte_o     = out_byte_q;
  assign frame_last_o   = out_last_q;

endmodule

/* hw/rtl/image_border_padding.sv */
// Image border padding with constant, replicate, reflect, reflect-101 and wrap rules.
// Channels: in_if carries items with req_type and src_byte; a load (req_type 0)
// writes src_byte at the next source address and gives no result, an emit
// (req_type 1) returns the next padded byte on out_if, frame_last marking the final
// byte of the padded frame. cfg_if writes registers 0..7 (width, height, pads
// top/bottom/left/right, border mode, fill bytes) between items.
// Throughput: one item at a time. A load writes one byte. An emit runs the modulo
// steps of the border mapping, one subtract or add per cycle on both coordinates at
// once, then address, read and output; no modulo steps for in-range pixels and
// constant or replicate mode, up to about (pad + size) / period for reflect and wrap.
// The output register frees the input side: a new item is taken while a result
// waits, and an emit holds in its last step until the output register is free.
// Reset: registers go to 64x64, no padding, constant mode, fill zero; load and
// output positions return to zero. The frame store is not cleared; load the
// image before emitting.
`include "image_border_padding_macros.svh"

module image_border_padding import ibp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned CHANNELS   = 3,
  parameter int unsigned MAX_PAD    = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  ibp_in_if.sink    in_if,
  ibp_out_if.source out_if,
  ibp_cfg_if.sink   cfg_if
);

  ibp_cmd_t cmd;
  ibp_sts_t sts;

  assign cfg_if.ready = 1'b1;

  ibp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_if.valid),
    .req_type_i(in_if.req_type),
    .sts_i     (sts),
    .in_ready_o(in_if.ready),
    .cmd_o     (cmd)
  );

  ibp_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .CHANNELS  (CHANNELS),
    .MAX_PAD   (MAX_PAD)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (in_if.req_type),
    .src_byte_i  (in_if.src_byte),
    .cfg_we_i    (cfg_if.valid),
    .cfg_index_i (cfg_if.index),
    .cfg_data_i  (cfg_if.data),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .pad_byte_o  (out_if.pad_byte),
    .frame_last_o(out_if.frame_last)
  );

  `IBP_ASSERT(a_load_when_free, clk_i, rst_ni, cmd.out_load |-> (!out_if.valid || out_if.ready))
  `IBP_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_if.valid && in_if.ready) |=> !in_if.ready)
  `IBP_ASSERT(a_valid_from_load, clk_i, rst_ni, $rose(out_if.valid) |-> $past(cmd.out_load))
  `IBP_ASSERT_ALWAYS(a_one_store_op, clk_i, !(cmd.ld_write && cmd.rd_issue))

endmodule

/* tb/image_border_padding_checker.sv */
`timescale 1ns / 100ps

module image_border_padding_checker import ibp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned CHANNELS   = 3,
  parameter int unsigned MAX_PAD    = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  ibp_in_if    in_if,
  ibp_out_if   out_if,
  ibp_cfg_if   cfg_if,
  output int   fail_count,
  output int   pending,
  output int   frames_seen,
  output int   bytes_checked
);

  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;

  typedef struct {
    logic [BYTE_W-1:0] pad_byte;
    logic              frame_last;
  } pad_result_t;

  logic [CFG_W-1:0]  width_r, height_r, top_r, bottom_r, left_r, right_r;
  logic [MODE_W-1:0] mode_r;
  logic [FILL_W-1:0] fill_r;
  logic [BYTE_W-1:0] pix_store [STORE_DEPTH];
  int unsigned       ld_addr, col, row, chn;
  pad_result_t       padded_q[$];

  function automatic int clamp_size(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int wrap_pos(int a, int m);
    int r;
    r = a % m;
    return (r < 0) ? r + m : r;
  endfunction

  // source index for coordinate p, -1 means fill byte
  function automatic int map_to_source(int p, int n, logic [MODE_W-1:0] mode);
    int q;
    if (p >= 0 && p < n) return p;
    case (border_mode_e'(mode))
      MODE_REPLICATE: return (p < 0) ? 0 : n - 1;
      MODE_REFLECT: begin
        q = wrap_pos(p, 2 * n);
        return (q < n) ? q : 2 * n - 1 - q;
      end
      MODE_REFLECT_101: begin
        if (n == 1) return 0;
        q = wrap_pos(p, 2 * n - 2);
        return (q < n) ? q : 2 * n - 2 - q;
      end
      MODE_WRAP: return wrap_pos(p, n);
      default: return -1;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict
    int w, h, pt, pl, nw, nh, sc, sr, fbytes;
    int unsigned addr;
    pad_result_t exp_r;
    if (!rst_ni) begin
      width_r = 7'd64; height_r = 7'd64;
      top_r = '0; bottom_r = '0; left_r = '0; right_r = '0;
      mode_r = MODE_CONSTANT; fill_r = '0;
      ld_addr = 0; col = 0; row = 0; chn = 0;
      padded_q.delete();
      fail_count = 0; frames_seen = 0; bytes_checked = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_idx_e'(cfg_if.index))
          CFG_WIDTH:      width_r  = cfg_if.data[CFG_W-1:0];
          CFG_HEIGHT:     height_r = cfg_if.data[CFG_W-1:0];
          CFG_PAD_TOP:    top_r    = cfg_if.data[CFG_W-1:0];
          CFG_PAD_BOTTOM: bottom_r = cfg_if.data[CFG_W-1:0];
          CFG_PAD_LEFT:   left_r   = cfg_if.data[CFG_W-1:0];
          CFG_PAD_RIGHT:  right_r  = cfg_if.data[CFG_W-1:0];
          CFG_MODE:       mode_r   = cfg_if.data[MODE_W-1:0];
          CFG_FILL:       fill_r   = cfg_if.data;
          default: ;
        endcase
      end
      w  = clamp_size(width_r, 1, MAX_WIDTH);
      h  = clamp_size(height_r, 1, MAX_HEIGHT);
      pt = clamp_size(top_r, 0, MAX_PAD);
      pl = clamp_size(left_r, 0, MAX_PAD);
      nw = w + pl + clamp_size(right_r, 0, MAX_PAD);
      nh = h + pt + clamp_size(bottom_r, 0, MAX_PAD);
      fbytes = w * h * CHANNELS;
      if (in_if.valid && in_if.ready) begin
        if (!in_if.req_type) begin
          if (ld_addr >= fbytes) ld_addr = 0;
          pix_store[ld_addr] = in_if.src_byte;
          ld_addr++;
          if (ld_addr >= fbytes) ld_addr = 0;
        end else begin
          if (row >= nh || col >= nw || chn >= CHANNELS) begin
            row = 0; col = 0; chn = 0;
          end
          sc = map_to_source(int'(col) - pl, w, mode_r);
          sr = map_to_source(int'(row) - pt, h, mode_r);
          if (sc < 0 || sr < 0) begin
            exp_r.pad_byte = fill_r[8*chn +: 8];
          end else begin
            addr = (sr * w + sc) * CHANNELS + chn;
            exp_r.pad_byte = (addr < STORE_DEPTH) ? pix_store[addr] : '0;
          end
          exp_r.frame_last = (row == nh - 1) && (col == nw - 1) && (chn == CHANNELS - 1);
          padded_q.push_back(exp_r);
          chn++;
          if (chn >= CHANNELS) begin
            chn = 0;
            col++;
            if (col >= nw) begin
              col = 0;
              row++;
              if (row >= nh) row = 0;
            end
          end
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (padded_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected output item: pad_byte %02h frame_last %0b",
                   $time, out_if.pad_byte, out_if.frame_last);
        end else begin
          exp_r = padded_q.pop_front();
          bytes_checked++;
          if (out_if.frame_last) frames_seen++;
          if (out_if.pad_byte !== exp_r.pad_byte) begin
            fail_count++;
            $display("%0t: pad_byte mismatch: expected %02h actual %02h",
                     $time, exp_r.pad_byte, out_if.pad_byte);
          end
          if (out_if.frame_last !== exp_r.frame_last) begin
            fail_count++;
            $display("%0t: frame_last mismatch: expected %0b actual %0b",
                     $time, exp_r.frame_last, out_if.frame_last);
          end
        end
      end
    end
    pending = padded_q.size();
  end

endmodule

/* tb/image_border_padding_tb.sv */
`timescale 1ns / 100ps

module image_border_padding_tb import ibp_pkg::*; ();

  localparam int CHANNELS    = 3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 20;
  localparam int ITEM_GOAL   = 1550;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ibp_in_if  in_if ();
  ibp_out_if out_if ();
  ibp_cfg_if cfg_if ();

  logic              req_valid = 1'b0;
  logic              req_type = 1'b0;
  logic [BYTE_W-1:0] req_byte = '0;
  logic              res_ready = 1'b0;
  logic              wr_valid = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [FILL_W-1:0] wr_data = '0;

  assign in_if.valid    = req_valid;
  assign in_if.req_type = req_type;
  assign in_if.src_byte = req_byte;
  assign out_if.ready   = res_ready;
  assign cfg_if.valid   = wr_valid;
  assign cfg_if.index   = wr_index;
  assign cfg_if.data    = wr_data;

  int  fail_count, pending, frames_seen, bytes_checked;
  int  cycle_cnt = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;
  int  loads_sent = 0, emits_sent = 0, phases_run = 0;

  image_border_padding dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  image_border_padding_checker #(.CHANNELS(CHANNELS)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .out_if       (out_if),
    .cfg_if       (cfg_if),
    .fail_count   (fail_count),
    .pending      (pending),
    .frames_seen  (frames_seen),
    .bytes_checked(bytes_checked)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("image_border_padding regression: fail");
      $finish;
    end
  end

  // result side: random stall after each accepted item
  always @(posedge clk_i) begin
    int n;
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ready  <= 1'b0;
    end else if (res_ready && out_if.valid) begin
      n = quiet ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        res_ready  <= 1'b0;
        stall_left <= n - 1;
      end
    end else begin
      res_ready <= 1'b1;
    end
  end

  function automatic int clamp_size(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic send_request(input logic emit, input logic [BYTE_W-1:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_type  <= emit;
    req_byte  <= b;
    do @(negedge clk_i); while (!in_if.ready);
    @(posedge clk_i);
    if (emit) emits_sent++;
    else loads_sent++;
  endtask

  task automatic wait_quiet();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [FILL_W-1:0] d);
    wr_valid <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    do @(negedge clk_i); while (!cfg_if.ready);
    @(posedge clk_i);
  endtask

  // upper data bits are don't-care for narrow registers, so keep them random
  function automatic logic [FILL_W-1:0] junk_hi(input int v, input int bits);
    logic [FILL_W-1:0] r;
    r = $urandom;
    r = (r >> bits) << bits;
    return r | FILL_W'(v);
  endfunction

  task automatic run_phase(input int w, h, pt, pb, pl, pr, input logic [MODE_W-1:0] mode,
                           input logic [FILL_W-1:0] fill, input int n_items,
                           input int emit_pct, input bit hold);
    int fbytes;
    wait_quiet();
    write_reg(CFG_WIDTH, junk_hi(w, CFG_W));
    write_reg(CFG_HEIGHT, junk_hi(h, CFG_W));
    write_reg(CFG_PAD_TOP, junk_hi(pt, CFG_W));
    write_reg(CFG_PAD_BOTTOM, junk_hi(pb, CFG_W));
    write_reg(CFG_PAD_LEFT, junk_hi(pl, CFG_W));
    write_reg(CFG_PAD_RIGHT, junk_hi(pr, CFG_W));
    write_reg(CFG_MODE, junk_hi(mode, MODE_W));
    write_reg(CFG_FILL, fill);
    wr_valid <= 1'b0;
    @(posedge clk_i);
    quiet = ($urandom_range(0, 3) == 0);
    // fill every byte of the frame before any emit can read it
    fbytes = clamp_size(w, 1, 64) * clamp_size(h, 1, 64) * CHANNELS;
    repeat (fbytes) send_request(1'b0, BYTE_W'($urandom));
    for (int i = 0; i < n_items; i++) begin
      if (hold && i == n_items / 2) begin
        wait_quiet();
      end
      send_request($urandom_range(0, 99) < emit_pct, BYTE_W'($urandom));
    end
    phases_run++;
  endtask

  initial begin
    int w, h, pt, pb, pl, pr, n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: whole padded frames of small images per rule, then clamped sizes
    run_phase(1, 1, 1, 1, 1, 1, MODE_REFLECT_101, 32'h00FF_A55A, 30, 100, 1'b0);
    run_phase(2, 2, 2, 1, 1, 2, MODE_CONSTANT, 32'hFFFF_FFFF, 88, 100, 1'b1);
    run_phase(2, 3, 3, 0, 0, 3, MODE_REFLECT, 32'h0, 114, 100, 1'b0);
    run_phase(3, 1, 0, 2, 4, 4, MODE_WRAP, 32'h1234_5678, 99, 100, 1'b0);
    run_phase(1, 2, 2, 2, 2, 2, MODE_REPLICATE, 32'h0, 90, 100, 1'b0);
    run_phase(2, 2, 1, 0, 0, 1, 3'd7, 32'hC3C3_3C3C, 30, 100, 1'b0);
    run_phase(0, 0, 127, 127, 127, 127, MODE_REFLECT, 32'h0, 60, 100, 1'b0);
    run_phase(100, 1, 64, 64, 64, 64, MODE_REFLECT_101, 32'h0, 60, 90, 1'b0);
    run_phase(1, 64, 64, 0, 0, 0, MODE_WRAP, 32'h0, 40, 100, 1'b0);

    // random configurations until the total item count is reached
    while (loads_sent + emits_sent < ITEM_GOAL) begin
      w = $urandom_range(1, 5); h = $urandom_range(1, 5);
      pt = $urandom_range(0, 3); pb = $urandom_range(0, 3);
      pl = $urandom_range(0, 3); pr = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0: begin w = $urandom_range(60, 127); h = $urandom_range(0, 1); end
        1: begin h = $urandom_range(60, 127); w = $urandom_range(0, 1); end
        2: begin pl = $urandom_range(60, 127); pt = $urandom_range(60, 127); end
        3: begin pr = $urandom_range(60, 127); pb = $urandom_range(60, 127); end
        default: ;
      endcase
      n = $urandom_range(40, 160);
      run_phase(w, h, pt, pb, pl, pr, MODE_W'($urandom_range(0, 7)), $urandom,
                n, 80, $urandom_range(0, 3) == 0);
    end

    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("covered %0d configurations: %0d loads, %0d emits", phases_run, loads_sent,
             emits_sent);
    $display("checked %0d padded bytes, %0d complete frames", bytes_checked, frames_seen);
    if (fail_count == 0) begin
      $display("image_border_padding regression: pass");
    end else begin
      $display("image_border_padding regression: fail");
    end
    $finish;
  end

endmodule
